FILE: rtl/cie94_pkg.sv
// Shared widths, register indexes and beat types for the CIE94 difference pipeline.
`timescale 1ns / 1ps
package cie94_pkg;

  // Field widths
  localparam int LW      = 15;   // lightness
  localparam int AW      = 16;   // a and b axes
  localparam int OW      = 26;   // delta_e_squared
  localparam int KW      = 16;   // Q16 chroma and hue weights
  localparam int ROOT_W  = 16;   // chroma root
  localparam int RAD_W   = 32;   // a^2 + b^2
  localparam int DAB_W   = 33;   // da^2 + db^2
  localparam int T1_W    = 22;   // lightness term
  localparam int X_W     = 34;   // dividend numerator before the Q40 shift
  localparam int DIV_W   = 66;   // squared divisor in Q48
  localparam int Q_W     = 26;   // quotient bits of a weighted term

  // Pipeline depths
  localparam int ISQ_STAGES = ROOT_W;
  localparam int DIV_STAGES = Q_W;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_CHROMA_WEIGHT     = 2'd0;
  localparam logic [1:0] CFG_HUE_WEIGHT        = 2'd1;
  localparam logic [1:0] CFG_LIGHTNESS_DIVISOR = 2'd2;

  // Reset values of the registers
  localparam logic [KW-1:0] CHROMA_WEIGHT_RST = 16'd2949;
  localparam logic [KW-1:0] HUE_WEIGHT_RST    = 16'd983;
  localparam logic [1:0]    LIGHTNESS_DIV_RST = 2'd1;

  // Values that travel beside the two roots
  typedef struct packed {
    logic [DAB_W-1:0] dab2;
    logic [T1_W-1:0]  t1;
  } cie94_side_t;

endpackage

FILE: rtl/cie94_isqrt.sv
// Two-lane pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module cie94_isqrt
  import cie94_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [RAD_W-1:0]    in_rad1,
  input  logic [RAD_W-1:0]    in_rad2,
  input  cie94_side_t         in_side,
  output logic                out_vld,
  output logic [ROOT_W-1:0]   out_root1,
  output logic [ROOT_W-1:0]   out_root2,
  output cie94_side_t         out_side
);

  logic                vld_r   [ISQ_STAGES];
  logic [RAD_W-1:0]    rem_r   [ISQ_STAGES][2];
  logic [ROOT_W-1:0]   root_r  [ISQ_STAGES][2];
  cie94_side_t         side_r  [ISQ_STAGES];
  logic [RAD_W-1:0]    rem_nxt [ISQ_STAGES][2];
  logic [ROOT_W-1:0]   root_nxt[ISQ_STAGES][2];

  // Settle one root bit per stage, most significant first
  always_comb begin
    logic [RAD_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    logic [RAD_W+1:0]  trial;
    int                b;
    for (int k = 0; k < ISQ_STAGES; k++) begin
      b = ISQ_STAGES - 1 - k;
      for (int n = 0; n < 2; n++) begin
        if (k == 0) begin
          src_rem  = (n == 0) ? in_rad1 : in_rad2;
          src_root = '0;
        end else begin
          src_rem  = rem_r[k-1][n];
          src_root = root_r[k-1][n];
        end
        trial = ((RAD_W+2)'(src_root) << (b + 1)) + ((RAD_W+2)'(1) << (2 * b));
        if ({2'b00, src_rem} >= trial) begin
          rem_nxt[k][n]  = src_rem - trial[RAD_W-1:0];
          root_nxt[k][n] = src_root | (ROOT_W'(1) << b);
        end else begin
          rem_nxt[k][n]  = src_rem;
          root_nxt[k][n] = src_root;
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < ISQ_STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= (k == 0) ? in_vld : vld_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < ISQ_STAGES; k++) begin
      side_r[k] <= (k == 0) ? in_side : side_r[k-1];
      for (int n = 0; n < 2; n++) begin
        rem_r[k][n]  <= rem_nxt[k][n];
        root_r[k][n] <= root_nxt[k][n];
      end
    end
  end

  assign out_vld   = vld_r[ISQ_STAGES-1];
  assign out_root1 = root_r[ISQ_STAGES-1][0];
  assign out_root2 = root_r[ISQ_STAGES-1][1];
  assign out_side  = side_r[ISQ_STAGES-1];

endmodule

FILE: rtl/cie94_wdiv.sv
// Two-lane pipelined restoring divider for floor(x * 2^40 / d), one quotient bit per stage.
`timescale 1ns / 1ps
module cie94_wdiv
  import cie94_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [X_W-1:0]     in_x1,
  input  logic [DIV_W-1:0]   in_d1,
  input  logic [X_W-1:0]     in_x2,
  input  logic [DIV_W-1:0]   in_d2,
  input  logic [T1_W-1:0]    in_t1,
  output logic               out_vld,
  output logic [Q_W-1:0]     out_q1,
  output logic [Q_W-1:0]     out_q2,
  output logic [T1_W-1:0]    out_t1
);

  localparam int PRE_SHIFT = 40 - Q_W;

  logic               vld_r  [DIV_STAGES];
  logic [DIV_W-1:0]   rem_r  [DIV_STAGES][2];
  logic [DIV_W-1:0]   den_r  [DIV_STAGES][2];
  logic [Q_W-1:0]     quo_r  [DIV_STAGES][2];
  logic [T1_W-1:0]    t1_r   [DIV_STAGES];
  logic [DIV_W-1:0]   rem_nxt[DIV_STAGES][2];
  logic [DIV_W-1:0]   den_nxt[DIV_STAGES][2];
  logic [Q_W-1:0]     quo_nxt[DIV_STAGES][2];

  // Shift in one numerator bit and try the divisor
  always_comb begin
    logic [DIV_W-1:0] src_rem;
    logic [DIV_W-1:0] src_den;
    logic [Q_W-1:0]   src_quo;
    logic [DIV_W:0]   dbl;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int n = 0; n < 2; n++) begin
        if (k == 0) begin
          src_rem = (n == 0) ? DIV_W'({in_x1, {PRE_SHIFT{1'b0}}})
                             : DIV_W'({in_x2, {PRE_SHIFT{1'b0}}});
          src_den = (n == 0) ? in_d1 : in_d2;
          src_quo = '0;
        end else begin
          src_rem = rem_r[k-1][n];
          src_den = den_r[k-1][n];
          src_quo = quo_r[k-1][n];
        end
        dbl = {src_rem, 1'b0};
        den_nxt[k][n] = src_den;
        if (dbl >= {1'b0, src_den}) begin
          rem_nxt[k][n] = DIV_W'(dbl - {1'b0, src_den});
          quo_nxt[k][n] = {src_quo[Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][n] = dbl[DIV_W-1:0];
          quo_nxt[k][n] = {src_quo[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= (k == 0) ? in_vld : vld_r[k-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      t1_r[k] <= (k == 0) ? in_t1 : t1_r[k-1];
      for (int n = 0; n < 2; n++) begin
        rem_r[k][n] <= rem_nxt[k][n];
        den_r[k][n] <= den_nxt[k][n];
        quo_r[k][n] <= quo_nxt[k][n];
      end
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_q1  = quo_r[DIV_STAGES-1][0];
  assign out_q2  = quo_r[DIV_STAGES-1][1];
  assign out_t1  = t1_r[DIV_STAGES-1];

endmodule

FILE: rtl/cie94_color_difference.sv
// Top level of the squared CIE94 color difference pipeline.
//
//   channel  ports                                  flow
//   input    start, busy, in_ref_*, in_smp_*         beat taken when start && !busy
//   result   out_valid, out_delta_e_squared          one-cycle strobe, no back-pressure
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  write when valid && ready
//
// One beat can enter every cycle; busy stays low and cfg_ready stays high.
// out_valid follows the taken beat through stages 1 to 4, the 16-stage chroma square
// root, stages A to C, the 26-stage quotient pipeline and the output register.
// Synchronous active-low reset clears valid bits and loads the weight defaults.
// Nothing stalls: the receiver takes every result in its strobe cycle.
`timescale 1ns / 1ps
module cie94_color_difference
  import cie94_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [LW-1:0]       in_ref_l,
  input  logic signed [AW-1:0] in_ref_a,
  input  logic signed [AW-1:0] in_ref_b,
  input  logic [LW-1:0]       in_smp_l,
  input  logic signed [AW-1:0] in_smp_a,
  input  logic signed [AW-1:0] in_smp_b,
  output logic                out_valid,
  output logic [OW-1:0]       out_delta_e_squared,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [KW-1:0]       cfg_data
);

  localparam logic [22:0] RECIP9     = 23'd7456541;   // ceil(2^26 / 9)
  localparam int          RECIP_SH   = 26;
  localparam logic [OW:0] OUT_MAX    = {1'b0, {OW{1'b1}}};

  // Configuration registers
  logic [KW-1:0] chroma_weight_r;
  logic [KW-1:0] hue_weight_r;
  logic [1:0]    lightness_div_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chroma_weight_r <= CHROMA_WEIGHT_RST;
      hue_weight_r    <= HUE_WEIGHT_RST;
      lightness_div_r <= LIGHTNESS_DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHROMA_WEIGHT:     chroma_weight_r <= cfg_data;
        CFG_HUE_WEIGHT:        hue_weight_r    <= cfg_data;
        CFG_LIGHTNESS_DIVISOR: lightness_div_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: capture the beat
  logic                 s1_vld_r;
  logic [LW-1:0]        s1_rl_r, s1_sl_r;
  logic signed [AW-1:0] s1_ra_r, s1_rb_r, s1_sa_r, s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_rl_r <= in_ref_l;
    s1_ra_r <= in_ref_a;
    s1_rb_r <= in_ref_b;
    s1_sl_r <= in_smp_l;
    s1_sa_r <= in_smp_a;
    s1_sb_r <= in_smp_b;
  end

  // Stage 2: squares of the axes and magnitudes of the differences
  logic                 s2_vld_r;
  logic [RAD_W-1:0]     s2_ra2_r, s2_rb2_r, s2_sa2_r, s2_sb2_r;
  logic [AW-1:0]        s2_da_r, s2_db_r;
  logic [LW-1:0]        s2_dl_r;
  logic [AW-1:0]        mag_ra, mag_rb, mag_sa, mag_sb;
  logic signed [AW:0]   da_s, db_s;
  logic signed [LW:0]   dl_s;

  always_comb begin
    mag_ra = s1_ra_r[AW-1] ? AW'(-s1_ra_r) : s1_ra_r;
    mag_rb = s1_rb_r[AW-1] ? AW'(-s1_rb_r) : s1_rb_r;
    mag_sa = s1_sa_r[AW-1] ? AW'(-s1_sa_r) : s1_sa_r;
    mag_sb = s1_sb_r[AW-1] ? AW'(-s1_sb_r) : s1_sb_r;
    da_s   = {s1_ra_r[AW-1], s1_ra_r} - {s1_sa_r[AW-1], s1_sa_r};
    db_s   = {s1_rb_r[AW-1], s1_rb_r} - {s1_sb_r[AW-1], s1_sb_r};
    dl_s   = $signed({1'b0, s1_rl_r}) - $signed({1'b0, s1_sl_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_ra2_r <= mag_ra * mag_ra;
    s2_rb2_r <= mag_rb * mag_rb;
    s2_sa2_r <= mag_sa * mag_sa;
    s2_sb2_r <= mag_sb * mag_sb;
    s2_da_r  <= da_s[AW] ? AW'(-da_s) : da_s[AW-1:0];
    s2_db_r  <= db_s[AW] ? AW'(-db_s) : db_s[AW-1:0];
    s2_dl_r  <= dl_s[LW] ? LW'(-dl_s) : dl_s[LW-1:0];
  end

  // Stage 3: radii and squared differences
  logic                 s3_vld_r;
  logic [RAD_W-1:0]     s3_rad1_r, s3_rad2_r, s3_da2_r, s3_db2_r;
  logic [2*LW-1:0]      s3_dl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    s3_rad1_r <= s2_ra2_r + s2_rb2_r;
    s3_rad2_r <= s2_sa2_r + s2_sb2_r;
    s3_da2_r  <= s2_da_r * s2_da_r;
    s3_db2_r  <= s2_db_r * s2_db_r;
    s3_dl2_r  <= s2_dl_r * s2_dl_r;
  end

  // Stage 4: combined axis difference and the divide-by-nine product
  logic                 s4_vld_r;
  logic [RAD_W-1:0]     s4_rad1_r, s4_rad2_r;
  logic [DAB_W-1:0]     s4_dab2_r;
  logic [2*LW-1:0]      s4_dl2_r;
  logic [T1_W+22:0]     s4_prod_r;
  logic [T1_W-1:0]      dl2_q8;
  logic [T1_W-1:0]      t1_sel;
  cie94_side_t          isq_side_in;

  assign dl2_q8 = s3_dl2_r[2*LW-1:8];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    s4_rad1_r <= s3_rad1_r;
    s4_rad2_r <= s3_rad2_r;
    s4_dab2_r <= DAB_W'(s3_da2_r) + DAB_W'(s3_db2_r);
    s4_dl2_r  <= s3_dl2_r;
    s4_prod_r <= dl2_q8 * RECIP9;
  end

  // Pick the lightness term by kL; zero acts as one
  always_comb begin
    case (lightness_div_r) inside
      2'd0, 2'd1: t1_sel = s4_dl2_r[2*LW-1:8];
      2'd2:       t1_sel = T1_W'(s4_dl2_r[2*LW-1:10]);
      default:    t1_sel = T1_W'(s4_prod_r[T1_W+22:RECIP_SH]);
    endcase
    isq_side_in.dab2 = s4_dab2_r;
    isq_side_in.t1   = t1_sel;
  end

  // Chroma roots of reference and sample
  logic                isq_vld;
  logic [ROOT_W-1:0]   isq_c1, isq_c2;
  cie94_side_t         isq_side;

  cie94_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s4_vld_r),
    .in_rad1   (s4_rad1_r),
    .in_rad2   (s4_rad2_r),
    .in_side   (isq_side_in),
    .out_vld   (isq_vld),
    .out_root1 (isq_c1),
    .out_root2 (isq_c2),
    .out_side  (isq_side)
  );

  // Stage A: chroma difference squared and weighted reference chroma
  logic                 sa_vld_r;
  logic [2*ROOT_W-1:0]  sa_dc2_r;
  logic [KW+ROOT_W-1:0] sa_p1_r, sa_p2_r;
  cie94_side_t          sa_side_r;
  logic [ROOT_W-1:0]    dc_mag;

  assign dc_mag = (isq_c1 >= isq_c2) ? (isq_c1 - isq_c2) : (isq_c2 - isq_c1);

  always_ff @(posedge clk) begin
    if (!rst_n) sa_vld_r <= 1'b0;
    else        sa_vld_r <= isq_vld;
  end

  always_ff @(posedge clk) begin
    sa_dc2_r  <= dc_mag * dc_mag;
    sa_p1_r   <= chroma_weight_r * isq_c1;
    sa_p2_r   <= hue_weight_r * isq_c1;
    sa_side_r <= isq_side;
  end

  // Stage B: clamped hue square and squares of the weighted chroma
  logic                     sb_vld_r;
  logic [DAB_W-1:0]         sb_dh2_r;
  logic [2*ROOT_W-1:0]      sb_dc2_r;
  logic [KW+ROOT_W-1:0]     sb_p1_r, sb_p2_r;
  logic [2*(KW+ROOT_W)-1:0] sb_pp1_r, sb_pp2_r;
  logic [T1_W-1:0]          sb_t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_vld_r <= 1'b0;
    else        sb_vld_r <= sa_vld_r;
  end

  always_ff @(posedge clk) begin
    sb_dh2_r <= (sa_side_r.dab2 >= DAB_W'(sa_dc2_r)) ?
                (sa_side_r.dab2 - DAB_W'(sa_dc2_r)) : '0;
    sb_dc2_r <= sa_dc2_r;
    sb_p1_r  <= sa_p1_r;
    sb_p2_r  <= sa_p2_r;
    sb_pp1_r <= sa_p1_r * sa_p1_r;
    sb_pp2_r <= sa_p2_r * sa_p2_r;
    sb_t1_r  <= sa_side_r.t1;
  end

  // Stage C: divisors (2^24 + k*C1)^2 in Q48
  logic               sc_vld_r;
  logic [X_W-1:0]     sc_x1_r, sc_x2_r;
  logic [DIV_W-1:0]   sc_d1_r, sc_d2_r;
  logic [T1_W-1:0]    sc_t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sc_vld_r <= 1'b0;
    else        sc_vld_r <= sb_vld_r;
  end

  always_ff @(posedge clk) begin
    sc_x1_r <= X_W'(sb_dc2_r);
    sc_x2_r <= X_W'(sb_dh2_r);
    sc_d1_r <= (DIV_W'(1) << 48) + (DIV_W'(sb_p1_r) << 25) + DIV_W'(sb_pp1_r);
    sc_d2_r <= (DIV_W'(1) << 48) + (DIV_W'(sb_p2_r) << 25) + DIV_W'(sb_pp2_r);
    sc_t1_r <= sb_t1_r;
  end

  // Chroma and hue terms
  logic              dv_vld;
  logic [Q_W-1:0]    dv_t2, dv_t3;
  logic [T1_W-1:0]   dv_t1;

  cie94_wdiv u_wdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_vld_r),
    .in_x1   (sc_x1_r),
    .in_d1   (sc_d1_r),
    .in_x2   (sc_x2_r),
    .in_d2   (sc_d2_r),
    .in_t1   (sc_t1_r),
    .out_vld (dv_vld),
    .out_q1  (dv_t2),
    .out_q2  (dv_t3),
    .out_t1  (dv_t1)
  );

  // Output stage: sum and saturate
  logic              out_vld_r;
  logic [OW-1:0]     out_des_r;
  logic [OW+1:0]     sum;

  assign sum = (OW+2)'(dv_t1) + (OW+2)'(dv_t2) + (OW+2)'(dv_t3);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    out_des_r <= (sum > (OW+2)'(OUT_MAX)) ? OUT_MAX[OW-1:0] : sum[OW-1:0];
  end

  assign out_valid           = out_vld_r;
  assign out_delta_e_squared = out_des_r;

endmodule

FILE: dv/cie94_checker.sv
// Checker that predicts and compares the squared CIE94 difference results.
`timescale 1ns / 1ps
module cie94_checker
  import cie94_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [LW-1:0]        in_ref_l,
  input  logic signed [AW-1:0] in_ref_a,
  input  logic signed [AW-1:0] in_ref_b,
  input  logic [LW-1:0]        in_smp_l,
  input  logic signed [AW-1:0] in_smp_a,
  input  logic signed [AW-1:0] in_smp_b,
  input  logic                 out_valid,
  input  logic [OW-1:0]        out_delta_e_squared,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [KW-1:0]        cfg_data,
  output int                   mismatches,
  output int                   pending
);

  localparam longint unsigned DE_MAX = 64'd67108863;

  logic [KW-1:0] k1_q16;
  logic [KW-1:0] k2_q16;
  logic [1:0]    kl_reg;
  logic [OW-1:0] delta_e_expected[$];

  // Truncated integer square root
  function automatic longint unsigned chroma_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(x * 2^40 / s^2) by long division
  function automatic longint unsigned weighted_quotient(longint unsigned x,
                                                        longint unsigned s);
    longint unsigned q;
    longint unsigned r;
    q = x / s;
    r = x % s;
    for (int i = 0; i < 40; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= s) begin
        r = r - s;
        q = q | 64'd1;
      end
    end
    return q / s;
  endfunction

  function automatic logic [OW-1:0] cie94_delta_e_sq(
      logic [LW-1:0] rl, logic signed [AW-1:0] ra, logic signed [AW-1:0] rb,
      logic [LW-1:0] sl, logic signed [AW-1:0] sa, logic signed [AW-1:0] sb);
    longint dl, c1, c2, dc, da, db, dh2;
    longint unsigned kl, sc, sh, t1, t2, t3, sum;
    dl  = longint'(rl) - longint'(sl);
    c1  = longint'(chroma_root(longint'(ra) * ra + longint'(rb) * rb));
    c2  = longint'(chroma_root(longint'(sa) * sa + longint'(sb) * sb));
    dc  = c1 - c2;
    da  = longint'(ra) - longint'(sa);
    db  = longint'(rb) - longint'(sb);
    dh2 = da * da + db * db - dc * dc;
    // clamp a negative hue square, treat a zero divisor as one
    if (dh2 < 0) dh2 = 0;
    kl  = (kl_reg == 2'd0) ? 64'd1 : 64'(kl_reg);
    sc  = (64'd1 << 24) + 64'(k1_q16) * 64'(c1);
    sh  = (64'd1 << 24) + 64'(k2_q16) * 64'(c1);
    t1  = 64'(dl * dl) / (64'd256 * kl * kl);
    t2  = weighted_quotient(64'(dc * dc), sc);
    t3  = weighted_quotient(64'(dh2), sh);
    sum = t1 + t2 + t3;
    if (sum > DE_MAX) sum = DE_MAX;
    return sum[OW-1:0];
  endfunction

  // Track registers, predict each input beat, compare each result beat
  always @(posedge clk) begin
    logic [OW-1:0] want;
    if (!rst_n) begin
      k1_q16     <= CHROMA_WEIGHT_RST;
      k2_q16     <= HUE_WEIGHT_RST;
      kl_reg     <= LIGHTNESS_DIV_RST;
      mismatches <= 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHROMA_WEIGHT: begin
            k1_q16 <= cfg_data;
          end
          CFG_HUE_WEIGHT: begin
            k2_q16 <= cfg_data;
          end
          CFG_LIGHTNESS_DIVISOR: begin
            kl_reg <= cfg_data[1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_valid) begin
        if (delta_e_expected.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result beat: delta_e_squared=%0d", out_delta_e_squared);
        end else begin
          want = delta_e_expected.pop_front();
          if (want !== out_delta_e_squared) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("delta_e_squared mismatch: expected %0d, got %0d",
                       want, out_delta_e_squared);
          end
        end
      end
      if (start && !busy)
        delta_e_expected.push_back(cie94_delta_e_sq(in_ref_l, in_ref_a, in_ref_b,
                                                    in_smp_l, in_smp_a, in_smp_b));
      // Publish the number of results still owed
      pending = delta_e_expected.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the CIE94 difference testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import cie94_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [LW-1:0]        in_ref_l;
  logic signed [AW-1:0] in_ref_a;
  logic signed [AW-1:0] in_ref_b;
  logic [LW-1:0]        in_smp_l;
  logic signed [AW-1:0] in_smp_a;
  logic signed [AW-1:0] in_smp_b;
  logic                 out_valid;
  logic [OW-1:0]        out_delta_e_squared;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [KW-1:0]        cfg_data;
  int                   mismatches;
  int                   pending;
  int                   cycles;
  int                   burst_left;

  cie94_color_difference uut (.*);
  cie94_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one color pair, with a random gap at burst boundaries
  task automatic send_pair(int rl, int ra, int rb, int sl, int sa, int sb);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    start    <= 1'b1;
    in_ref_l <= rl[LW-1:0];
    in_ref_a <= ra[AW-1:0];
    in_ref_b <= rb[AW-1:0];
    in_smp_l <= sl[LW-1:0];
    in_smp_a <= sa[AW-1:0];
    in_smp_b <= sb[AW-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold until every result beat has come
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[KW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pairs(int count);
    int rl, ra, rb;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          // near-neutral colors with small differences
          rl = $urandom_range(0, 25600);
          ra = $urandom_range(0, 2000) - 1000;
          rb = $urandom_range(0, 2000) - 1000;
          send_pair(rl, ra, rb, rl + $urandom_range(0, 64) - 32,
                    ra + $urandom_range(0, 64) - 32, rb + $urandom_range(0, 64) - 32);
        end
        1: begin
          send_pair($urandom_range(0, 25600), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 25600),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
        default: begin
          send_pair($urandom_range(0, 32767), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 32767),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
      endcase
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CHROMA_WEIGHT;
    cfg_data   = '0;
    in_ref_l   = '0;
    in_ref_a   = '0;
    in_ref_b   = '0;
    in_smp_l   = '0;
    in_smp_a   = '0;
    in_smp_b   = '0;
    cycles     = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed extremes under reset weights
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(25600, 0, 0, 0, 0, 0);
    send_pair(32767, 32767, 32767, 0, -32768, -32768);
    send_pair(0, -32768, -32768, 32767, 32767, 32767);
    send_pair(12800, 32767, 0, 12800, 0, 32767);
    send_pair(12800, -32768, 0, 12800, 32767, 0);
    send_pair(25600, 1, 1, 25600, 1, 0);
    send_pair(5000, 300, -200, 5000, 300, -200);
    send_pair(32767, -32768, 32767, 32767, 32767, -32768);
    send_pair(100, 0, -32768, 25600, 0, 0);

    // Zero weights, textile divisor
    write_reg(CFG_CHROMA_WEIGHT, 0);
    write_reg(CFG_HUE_WEIGHT, 0);
    write_reg(CFG_LIGHTNESS_DIVISOR, 2);
    send_pair(32767, 32767, 32767, 0, -32768, -32768);
    send_pair(0, -32768, 32767, 32767, 32767, -32768);
    random_pairs(300);

    // Maximum weights, zero divisor acts as one
    write_reg(CFG_CHROMA_WEIGHT, 65535);
    write_reg(CFG_HUE_WEIGHT, 65535);
    write_reg(CFG_LIGHTNESS_DIVISOR, 0);
    send_pair(32767, 32767, 32767, 0, -32768, -32768);
    random_pairs(300);

    // Divisor of three; index beyond the list is dropped
    write_reg(CFG_LIGHTNESS_DIVISOR, 3);
    write_reg(2'd3, 16'hFFFF);
    send_pair(32767, 100, -100, 0, -100, 100);
    random_pairs(300);

    // Random weights
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_CHROMA_WEIGHT, $urandom_range(0, 65535));
      write_reg(CFG_HUE_WEIGHT, $urandom_range(0, 65535));
      write_reg(CFG_LIGHTNESS_DIVISOR, $urandom_range(0, 3));
      random_pairs(200);
    end

    // Back to graphic-arts defaults
    write_reg(CFG_CHROMA_WEIGHT, 2949);
    write_reg(CFG_HUE_WEIGHT, 983);
    write_reg(CFG_LIGHTNESS_DIVISOR, 1);
    random_pairs(450);

    drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cie94_pkg.sv
rtl/cie94_isqrt.sv
rtl/cie94_wdiv.sv
rtl/cie94_color_difference.sv
dv/cie94_checker.sv
dv/testbench.sv
